[rtl/tmstep_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmstep_pkg
// Types, constants and the transition lookup shared by the Turing machine
// stepper.
// ----------------------------------------------------------------------------
package tmstep_pkg;

    localparam int TABLE_W  = 50;
    localparam int ENTRY_W  = 5;
    localparam int STATE_W  = 3;
    localparam int STEP_W   = 48;
    localparam int BUDGET_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [TABLE_W-1:0]  TABLE_RESET = 50'd25737070619943;
    localparam logic [STATE_W-1:0]  STATE_A     = 3'd0;
    localparam logic [STATE_W-1:0]  HALT_STATE  = 3'd5;
    localparam logic [3:0]          ENTRY_LAST  = 4'd9;

    localparam logic [STATUS_W-1:0] STATUS_HALTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BUDGET = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAULT  = 2'd2;

    typedef struct packed {
        logic [STATE_W-1:0] next;
        logic               right;
        logic               wr;
    } entry_t;

    // Selects the table entry for a state and the symbol under the head.
    function automatic entry_t table_entry(input logic [TABLE_W-1:0] tbl,
                                           input logic [STATE_W-1:0] st,
                                           input logic sym);
        logic [3:0] idx;
        idx = {st, sym};
        if (idx > ENTRY_LAST) begin
            idx = ENTRY_LAST;
        end
        return entry_t'(tbl[idx*ENTRY_W +: ENTRY_W]);
    endfunction

endpackage
`default_nettype wire

[rtl/tmstep_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmstep_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tmstep_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/two_symbol_turing_machine_stepper_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_symbol_turing_machine_stepper_top
// Five-state, two-symbol Turing machine stepper with the tape kept as two
// stacks in RAM around a head cell register.
// ----------------------------------------------------------------------------
// Each input beat optionally restarts the machine on a blank tape and then
// runs machine steps until the machine halts, a stack overflows or the
// beat's step budget is used up; one result beat reports the outcome. Every
// machine step passes through the ST_STEP and ST_LOAD states: ST_STEP looks
// up the transition, pushes the written cell onto one stack RAM and issues
// the pop read on the other, and ST_LOAD loads the head cell from the
// registered read data. A step that would overflow a stack raises the fault
// flag instead, and the result waits for a free result slot. The stack RAMs
// need no clearing pass after reset, since only entries below a stack's
// count are ever used.
// ----------------------------------------------------------------------------
module two_symbol_turing_machine_stepper_top
    import tmstep_pkg::*;
#(
    parameter int TAPE_HALF = 65536
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [TABLE_W-1:0]  cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_command,
    input  wire logic [BUDGET_W-1:0] s_step_budget,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [STEP_W-1:0]   m_total_steps,
    output logic      [STATUS_W-1:0] m_run_status,
    output logic      [STATE_W-1:0]  m_machine_state,
    output logic                     m_head_symbol
);

    localparam int ADDR_W = $clog2(TAPE_HALF);
    localparam int CNT_W  = $clog2(TAPE_HALF + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TAPE_HALF);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]          fsm_reg,        fsm_next;
    logic [TABLE_W-1:0]  table_reg,      table_next;
    logic [STATE_W-1:0]  ctrl_state_reg, ctrl_state_next;
    logic                head_reg,       head_next;
    logic [CNT_W-1:0]    lcnt_reg,       lcnt_next;
    logic [CNT_W-1:0]    rcnt_reg,       rcnt_next;
    logic [STEP_W-1:0]   steps_reg,      steps_next;
    logic                fault_reg,      fault_next;
    logic [BUDGET_W-1:0] budget_reg,     budget_next;
    logic                pop_empty_reg,  pop_empty_next;
    logic                pop_left_reg,   pop_left_next;
    logic                m_valid_reg,    m_valid_next;
    logic [STEP_W-1:0]   out_steps_reg,  out_steps_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [STATE_W-1:0]  out_state_reg,  out_state_next;
    logic                out_head_reg,   out_head_next;

    entry_t           ent;
    logic             halted;
    logic             overflow;
    logic             stopping;
    logic             do_step;
    logic             load_out;
    logic [CNT_W-1:0] lcnt_dec;
    logic [CNT_W-1:0] rcnt_dec;
    logic             l_rdata;
    logic             r_rdata;

    assign ent      = table_entry(table_reg, ctrl_state_reg, head_reg);
    assign halted   = (ctrl_state_reg >= HALT_STATE);
    assign overflow = ent.right ? (lcnt_reg >= CNT_FULL) : (rcnt_reg >= CNT_FULL);
    assign stopping = halted || fault_reg || (budget_reg == '0);
    assign do_step  = (fsm_reg == ST_STEP) && !stopping && !overflow;
    assign load_out = (fsm_reg == ST_STEP) && stopping && (!m_valid_reg || m_ready);
    assign lcnt_dec = lcnt_reg - CNT_W'(1);
    assign rcnt_dec = rcnt_reg - CNT_W'(1);

    assign s_ready         = (fsm_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_total_steps   = out_steps_reg;
    assign m_run_status    = out_status_reg;
    assign m_machine_state = out_state_reg;
    assign m_head_symbol   = out_head_reg;

    tmstep_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_HALF)
    ) u_left_stack (
        .aclk    (aclk),
        .wr_en   (do_step && ent.right),
        .wr_addr (lcnt_reg[ADDR_W-1:0]),
        .wr_data (ent.wr),
        .rd_en   (do_step && !ent.right),
        .rd_addr (lcnt_dec[ADDR_W-1:0]),
        .rd_data (l_rdata)
    );

    tmstep_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_HALF)
    ) u_right_stack (
        .aclk    (aclk),
        .wr_en   (do_step && !ent.right),
        .wr_addr (rcnt_reg[ADDR_W-1:0]),
        .wr_data (ent.wr),
        .rd_en   (do_step && ent.right),
        .rd_addr (rcnt_dec[ADDR_W-1:0]),
        .rd_data (r_rdata)
    );

    always_comb begin
        fsm_next        = fsm_reg;
        table_next      = table_reg;
        ctrl_state_next = ctrl_state_reg;
        head_next       = head_reg;
        lcnt_next       = lcnt_reg;
        rcnt_next       = rcnt_reg;
        steps_next      = steps_reg;
        fault_next      = fault_reg;
        budget_next     = budget_reg;
        pop_empty_next  = pop_empty_reg;
        pop_left_next   = pop_left_reg;
        m_valid_next    = m_valid_reg;
        out_steps_next  = out_steps_reg;
        out_status_next = out_status_reg;
        out_state_next  = out_state_reg;
        out_head_next   = out_head_reg;

        if (cfg_wr_en) begin
            table_next = cfg_wr_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (fsm_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    budget_next = s_step_budget;
                    fsm_next    = ST_STEP;
                    if (s_command) begin
                        ctrl_state_next = STATE_A;
                        head_next       = 1'b0;
                        lcnt_next       = '0;
                        rcnt_next       = '0;
                        steps_next      = '0;
                        fault_next      = 1'b0;
                    end
                end
            end
            ST_STEP: begin
                if (stopping) begin
                    if (load_out) begin
                        m_valid_next   = 1'b1;
                        out_steps_next = steps_reg;
                        out_state_next = ctrl_state_reg;
                        out_head_next  = head_reg;
                        if (halted) begin
                            out_status_next = STATUS_HALTED;
                        end else if (fault_reg) begin
                            out_status_next = STATUS_FAULT;
                        end else begin
                            out_status_next = STATUS_BUDGET;
                        end
                        fsm_next = ST_IDLE;
                    end
                end else if (overflow) begin
                    fault_next = 1'b1;
                end else begin
                    budget_next     = budget_reg - BUDGET_W'(1);
                    ctrl_state_next = (ent.next >= HALT_STATE) ? HALT_STATE : ent.next;
                    if (steps_reg != '1) begin
                        steps_next = steps_reg + STEP_W'(1);
                    end
                    pop_left_next = !ent.right;
                    if (ent.right) begin
                        lcnt_next      = lcnt_reg + CNT_W'(1);
                        pop_empty_next = (rcnt_reg == '0);
                        if (rcnt_reg != '0) begin
                            rcnt_next = rcnt_dec;
                        end
                    end else begin
                        rcnt_next      = rcnt_reg + CNT_W'(1);
                        pop_empty_next = (lcnt_reg == '0);
                        if (lcnt_reg != '0) begin
                            lcnt_next = lcnt_dec;
                        end
                    end
                    fsm_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (pop_empty_reg) begin
                    head_next = 1'b0;
                end else begin
                    head_next = pop_left_reg ? l_rdata : r_rdata;
                end
                fsm_next = ST_STEP;
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= ST_IDLE;
            table_reg      <= TABLE_RESET;
            ctrl_state_reg <= STATE_A;
            head_reg       <= 1'b0;
            lcnt_reg       <= '0;
            rcnt_reg       <= '0;
            steps_reg      <= '0;
            fault_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fsm_reg        <= fsm_next;
            table_reg      <= table_next;
            ctrl_state_reg <= ctrl_state_next;
            head_reg       <= head_next;
            lcnt_reg       <= lcnt_next;
            rcnt_reg       <= rcnt_next;
            steps_reg      <= steps_next;
            fault_reg      <= fault_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        budget_reg     <= budget_next;
        pop_empty_reg  <= pop_empty_next;
        pop_left_reg   <= pop_left_next;
        out_steps_reg  <= out_steps_next;
        out_status_reg <= out_status_next;
        out_state_reg  <= out_state_next;
        out_head_reg   <= out_head_next;
    end

    // A performed step uses exactly one unit of the budget.
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> (budget_reg == $past(budget_reg) - BUDGET_W'(1)))
        else $error("budget not decremented by a step");

    // A step pushes one cell and pops one unless the popped stack was empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> (SUM_W'(lcnt_reg) + SUM_W'(rcnt_reg)
                     == SUM_W'($past(lcnt_reg)) + SUM_W'($past(rcnt_reg))
                        + SUM_W'($past(ent.right) ? $past(rcnt_reg == '0)
                                                  : $past(lcnt_reg == '0))))
        else $error("stack counts out of balance");

    // A halted machine stays halted until a new beat can restart it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg != ST_IDLE && ctrl_state_reg == HALT_STATE)
        |=> (ctrl_state_reg == HALT_STATE))
        else $error("halted machine left the halt state");

    // The fault flag is only raised by an overflowing step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fault_reg) |-> $past(fsm_reg == ST_STEP && overflow && !stopping))
        else $error("fault raised without overflow");

    // The stack counts never pass the tape half.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == ST_LOAD) |-> (lcnt_reg <= CNT_FULL && rcnt_reg <= CNT_FULL))
        else $error("stack count beyond capacity");

endmodule
`default_nettype wire
